// ----- hdl/ultrasonic_echo_ranger_unit_assert.svh -----
// Assertion macros for the echo ranger RTL.
// Used by the modules that check their own sequencing; needs clk and rst_n in scope.
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define UER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define UER_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UER_ASSERT(lbl, prop, msg)
`define UER_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hdl/uer_pkg.sv -----
// Shared types, constants and helpers of the echo ranger.
// No dependencies; every file but the assertion header imports it.
package uer_pkg;

  localparam int TIMER_BITS   = 16;
  localparam int CNT_BITS     = 8;
  localparam int SUM_BITS     = 24;
  localparam int AVG_BITS     = 16;
  localparam int TRIG_BITS    = 8;
  localparam int CFG_BITS     = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int DIV_STEPS    = SUM_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  localparam logic [CNT_BITS-1:0]   MAX_SAMPLES       = 8'd255;
  localparam logic [TRIG_BITS-1:0]  TRIGGER_US_RST    = 8'd10;
  localparam logic [TIMER_BITS-1:0] ECHO_TIMEOUT_RST  = 16'd5000;
  localparam logic [TIMER_BITS-1:0] MIN_CYCLE_RST     = 16'd60;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX         = {TIMER_BITS{1'b1}};
  localparam logic [SUM_BITS-1:0]   SUM_MAX           = {SUM_BITS{1'b1}};
  localparam logic [AVG_BITS-1:0]   AVG_MAX           = {AVG_BITS{1'b1}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TRIGGER_US   = 2'd0,
    CFG_ECHO_TIMEOUT = 2'd1,
    CFG_MIN_CYCLE    = 2'd2
  } cfg_idx_t;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_TRIG_LOW  = 6'b000010,
    PH_TRIG_HIGH = 6'b000100,
    PH_WAIT_RISE = 6'b001000,
    PH_TIME_HIGH = 6'b010000,
    PH_HOLD      = 6'b100000
  } phase_t;

  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] dividend;
    logic [CNT_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [AVG_BITS-1:0] quot;
  } div_rsp_t;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (v == TIMER_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ----- hdl/uer_in_if.sv -----
// Input tick channel: valid/ready plus the tick payload.
// Depends on uer_pkg for field widths.
interface uer_in_if import uer_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic                echo_level;
  logic [CNT_BITS-1:0] sample_count;

  modport source(output valid, cmd, echo_level, sample_count, input ready);
  modport sink(input valid, cmd, echo_level, sample_count, output ready);
endinterface

// ----- hdl/uer_out_if.sv -----
// Result channel: valid/ready plus the per-tick result payload.
// Depends on uer_pkg for field widths.
interface uer_out_if import uer_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                trigger_level;
  logic                busy_res;
  logic                done_res;
  logic                timed_out;
  logic [AVG_BITS-1:0] average_us;

  modport source(output valid, trigger_level, busy_res, done_res, timed_out, average_us,
                 input ready);
  modport sink(input valid, trigger_level, busy_res, done_res, timed_out, average_us,
               output ready);
endinterface

// ----- hdl/uer_div.sv -----
// Serial restoring divider: sum / count, one quotient bit per cycle.
// Depends on uer_pkg; quotient saturates to the average width.
`include "ultrasonic_echo_ranger_unit_assert.svh"
module uer_div import uer_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  typedef enum logic [1:0] {
    D_IDLE = 2'b01,
    D_RUN  = 2'b10
  } dstate_t;

  dstate_t                 dstate_r, dstate_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                    done_r, done_nxt;
  logic [SUM_BITS-1:0]     quo_r, quo_nxt;
  logic [CNT_BITS-1:0]     rem_r, rem_nxt;
  logic [CNT_BITS-1:0]     dvs_r, dvs_nxt;
  logic [CNT_BITS:0]       shifted;
  logic [CNT_BITS:0]       diff;
  logic                    ge;

  assign shifted = {rem_r, quo_r[SUM_BITS-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    dstate_nxt = dstate_r;
    cnt_nxt    = cnt_r;
    done_nxt   = 1'b0;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    dvs_nxt    = dvs_r;
    unique case (dstate_r)
      D_IDLE: begin
        if (req.start) begin
          quo_nxt    = req.dividend;
          rem_nxt    = '0;
          dvs_nxt    = req.divisor;
          cnt_nxt    = '0;
          dstate_nxt = D_RUN;
        end
      end
      D_RUN: begin
        // shift in the next dividend bit, subtract when it fits
        rem_nxt = ge ? diff[CNT_BITS-1:0] : shifted[CNT_BITS-1:0];
        quo_nxt = {quo_r[SUM_BITS-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
          done_nxt   = 1'b1;
          dstate_nxt = D_IDLE;
        end
      end
      default: dstate_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dstate_r <= D_IDLE;
      cnt_r    <= '0;
      done_r   <= 1'b0;
    end else begin
      dstate_r <= dstate_nxt;
      cnt_r    <= cnt_nxt;
      done_r   <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = (quo_r[SUM_BITS-1:AVG_BITS] != '0) ? AVG_MAX : quo_r[AVG_BITS-1:0];

  `UER_ASSERT(a_start_when_idle, req.start |-> (dstate_r == D_IDLE), "divider start while running")
  `UER_ASSERT(a_done_returns_idle, done_r |-> (dstate_r == D_IDLE), "divider done while running")
  `UER_ASSERT(a_cnt_in_range, (dstate_r == D_RUN) |-> (cnt_r < DIV_CNT_BITS'(DIV_STEPS)),
              "divider step count out of range")

endmodule

// ----- hdl/ultrasonic_echo_ranger_unit.sv -----
// Ultrasonic echo ranger. Each input beat is one microsecond tick carrying the echo
// level and an optional start command; each tick returns exactly one result beat with
// the trigger level, busy, done, timeout and average. A plain tick loads the result register
// on acceptance. A tick that ends a run with a nonzero count waits for its average, which
// comes from a serial divider that resolves one quotient bit per clock over 24 steps, and
// no new tick is taken until it finishes. A new tick is taken only while the result
// register is empty or its beat leaves in that same clock.
// Depends on uer_pkg, uer_in_if, uer_out_if, uer_div and the assertion header.
`include "ultrasonic_echo_ranger_unit_assert.svh"
module ultrasonic_echo_ranger_unit import uer_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx,
  input  logic [CFG_BITS-1:0]     cfg_wdata,
  uer_in_if.sink                  in_ch,
  uer_out_if.source               out_ch
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DIV  = 2'b10
  } seq_t;

  // configuration
  logic [TRIG_BITS-1:0]  trigger_us_r;
  logic [TIMER_BITS-1:0] echo_timeout_r;
  logic [TIMER_BITS-1:0] min_cycle_r;

  // measurement state
  phase_t                phase_r, ph_cur, ph_n;
  logic [TIMER_BITS-1:0] phase_timer_r, pt_n;
  logic [TIMER_BITS-1:0] since_r, st_n;
  logic [CNT_BITS-1:0]   samples_r, sd_n;
  logic [CNT_BITS-1:0]   req_cnt_r, rc_n;
  logic [SUM_BITS-1:0]   sum_r, ws_n;
  logic                  trig_n, done_n, tmo_n, send_n;
  logic [SUM_BITS:0]     sum_ext;
  logic [TIMER_BITS-1:0] tlen;
  logic [CNT_BITS-1:0]   cnt_in;

  // sequencer and result register
  seq_t                  seq_r, seq_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_trig_r, out_busy_r, out_done_r, out_tmo_r;
  logic [AVG_BITS-1:0]   out_avg_r, out_avg_nxt;
  logic                  accept, need_div;
  div_req_t              div_req;
  div_rsp_t              div_rsp;

  assign in_ch.ready = (seq_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign tlen   = (trigger_us_r == '0) ? TIMER_BITS'(1) : TIMER_BITS'(trigger_us_r);
  assign cnt_in = (in_ch.sample_count > MAX_SAMPLES) ? MAX_SAMPLES : in_ch.sample_count;

  // one tick of the measurement sequence
  always_comb begin
    ph_cur  = phase_r;
    pt_n    = phase_timer_r;
    st_n    = since_r;
    sd_n    = samples_r;
    rc_n    = req_cnt_r;
    ws_n    = sum_r;
    trig_n  = 1'b0;
    done_n  = 1'b0;
    tmo_n   = 1'b0;
    send_n  = 1'b0;
    sum_ext = '0;
    if (phase_r == PH_IDLE && in_ch.cmd) begin
      rc_n = cnt_in;
      sd_n = '0;
      ws_n = '0;
      pt_n = '0;
      st_n = '0;
      if (cnt_in == '0) begin
        done_n = 1'b1;
      end else begin
        ph_cur = PH_TRIG_LOW;
      end
    end
    ph_n = ph_cur;
    unique case (ph_cur)
      PH_IDLE: ;
      PH_TRIG_LOW, PH_TRIG_HIGH: begin
        trig_n = (ph_cur == PH_TRIG_HIGH);
        pt_n   = sat_inc(pt_n);
        if (pt_n >= tlen) begin
          pt_n = '0;
          if (ph_cur == PH_TRIG_LOW) begin
            ph_n = PH_TRIG_HIGH;
          end else begin
            ph_n = PH_WAIT_RISE;
            st_n = '0;
          end
        end
      end
      PH_WAIT_RISE: begin
        st_n = sat_inc(st_n);
        if (in_ch.echo_level) begin
          ph_n = PH_TIME_HIGH;
          pt_n = '0;
        end else if (st_n > echo_timeout_r) begin
          done_n = 1'b1;
          tmo_n  = 1'b1;
        end
      end
      PH_TIME_HIGH: begin
        st_n = sat_inc(st_n);
        pt_n = sat_inc(pt_n);
        if (!in_ch.echo_level) begin
          sum_ext = {1'b0, ws_n} + (SUM_BITS + 1)'(pt_n);
          ws_n    = sum_ext[SUM_BITS] ? SUM_MAX : sum_ext[SUM_BITS-1:0];
          if (st_n >= min_cycle_r) begin
            send_n = 1'b1;
          end else begin
            ph_n = PH_HOLD;
          end
        end else if (pt_n > echo_timeout_r) begin
          done_n = 1'b1;
          tmo_n  = 1'b1;
        end
      end
      PH_HOLD: begin
        st_n = sat_inc(st_n);
        if (st_n >= min_cycle_r) begin
          send_n = 1'b1;
        end
      end
      default: ph_n = PH_IDLE;
    endcase
    if (send_n) begin
      sd_n = sd_n + 1'b1;
      pt_n = '0;
      if (sd_n >= rc_n) begin
        done_n = 1'b1;
      end else begin
        ph_n = PH_TRIG_LOW;
      end
    end
    if (done_n) begin
      ph_n = PH_IDLE;
      pt_n = '0;
    end
  end

  assign need_div         = done_n && (rc_n != '0);
  assign div_req.start    = accept && need_div;
  assign div_req.dividend = ws_n;
  assign div_req.divisor  = rc_n;

  uer_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    seq_nxt       = seq_r;
    out_valid_nxt = out_valid_r;
    out_avg_nxt   = out_avg_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (seq_r)
      S_IDLE: begin
        if (accept) begin
          out_avg_nxt = '0;
          if (need_div) begin
            seq_nxt = S_DIV;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_DIV: begin
        // hold the flags, drop in the average when the divider finishes
        if (div_rsp.done) begin
          out_avg_nxt   = div_rsp.quot;
          out_valid_nxt = 1'b1;
          seq_nxt       = S_IDLE;
        end
      end
      default: seq_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_us_r   <= TRIGGER_US_RST;
      echo_timeout_r <= ECHO_TIMEOUT_RST;
      min_cycle_r    <= MIN_CYCLE_RST;
      phase_r        <= PH_IDLE;
      phase_timer_r  <= '0;
      since_r        <= '0;
      samples_r      <= '0;
      req_cnt_r      <= '0;
      sum_r          <= '0;
      seq_r          <= S_IDLE;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_TRIGGER_US:   trigger_us_r   <= cfg_wdata[TRIG_BITS-1:0];
          CFG_ECHO_TIMEOUT: echo_timeout_r <= cfg_wdata;
          CFG_MIN_CYCLE:    min_cycle_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        phase_r       <= ph_n;
        phase_timer_r <= pt_n;
        since_r       <= st_n;
        samples_r     <= sd_n;
        req_cnt_r     <= rc_n;
        sum_r         <= ws_n;
      end
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      out_trig_r <= trig_n;
      out_busy_r <= (ph_n != PH_IDLE);
      out_done_r <= done_n;
      out_tmo_r  <= tmo_n;
    end
    out_avg_r <= out_avg_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.trigger_level = out_trig_r;
  assign out_ch.busy_res      = out_busy_r;
  assign out_ch.done_res      = out_done_r;
  assign out_ch.timed_out     = out_tmo_r;
  assign out_ch.average_us    = out_avg_r;

  `UER_ASSERT(a_div_done_in_div, div_rsp.done |-> (seq_r == S_DIV), "divider result outside S_DIV")
  `UER_ASSERT(a_no_result_during_div, (seq_r == S_DIV) |-> !out_valid_nxt || div_rsp.done,
              "result raised before average ready")
  `UER_ASSERT(a_done_not_busy, out_valid_r && out_done_r |-> !out_busy_r,
              "run end reported as still busy")
  `UER_ASSERT(a_timeout_with_done, out_valid_r && out_tmo_r |-> out_done_r,
              "timeout flagged without done")

endmodule

// ----- tb/ultrasonic_echo_ranger_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ultrasonic_echo_ranger_unit: ticks go in through a driver,
// readings come back through a monitor and are checked against a tick-level predictor.
// Depends on uer_pkg, uer_in_if, uer_out_if and the RTL top.
module ultrasonic_echo_ranger_unit_test;
  import uer_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 40;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} pace_t;

  typedef struct packed {
    logic                start;
    logic                echo;
    logic [CNT_BITS-1:0] count;
  } tick_t;

  typedef struct packed {
    logic                trig;
    logic                busy;
    logic                done;
    logic                tmo;
    logic [AVG_BITS-1:0] avg;
  } reading_t;

  typedef struct {
    phase_t                ph;
    logic [TIMER_BITS-1:0] timer;
    logic [TIMER_BITS-1:0] since;
    logic [CNT_BITS-1:0]   taken;
    logic [CNT_BITS-1:0]   wanted;
    logic [SUM_BITS-1:0]   sum;
  } ranger_state_t;

  logic clk;
  logic rst_n;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
  logic [CFG_BITS-1:0] cfg_wdata = '0;

  uer_in_if  in_ch();
  uer_out_if out_ch();

  ultrasonic_echo_ranger_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // Register copies shared by the stimulus shaper and the checker side.
  logic [TRIG_BITS-1:0]  trig_len = TRIGGER_US_RST;
  logic [TIMER_BITS-1:0] echo_limit = ECHO_TIMEOUT_RST;
  logic [TIMER_BITS-1:0] min_gap = MIN_CYCLE_RST;

  ranger_state_t model_st;
  ranger_state_t gen_st;
  tick_t         tick_queue[$];
  reading_t      pending_readings[$];
  pace_t         pace = IDLE_NONE;
  int            made;
  int            mismatches = 0;
  int            quiet;

  function automatic ranger_state_t idle_state();
    ranger_state_t st;
    st.ph = PH_IDLE;
    st.timer = '0;
    st.since = '0;
    st.taken = '0;
    st.wanted = '0;
    st.sum = '0;
    return st;
  endfunction

  function automatic logic [TIMER_BITS-1:0] step_sat(input logic [TIMER_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // One microsecond tick of the ranger: advance st and return the reading it produces.
  function automatic reading_t ranger_tick(inout ranger_state_t st, input tick_t t);
    reading_t              r;
    logic [TIMER_BITS-1:0] tlen;
    logic [SUM_BITS:0]     s;
    logic [SUM_BITS-1:0]   q;
    logic                  sample_end;
    r = '0;
    sample_end = 1'b0;
    tlen = (trig_len == '0) ? TIMER_BITS'(1) : TIMER_BITS'(trig_len);
    if (st.ph == PH_IDLE && t.start) begin
      st.wanted = (t.count > MAX_SAMPLES) ? MAX_SAMPLES : t.count;
      st.taken = '0;
      st.sum = '0;
      st.timer = '0;
      st.since = '0;
      if (t.count == '0) r.done = 1'b1;
      else st.ph = PH_TRIG_LOW;
    end
    case (st.ph)
      PH_TRIG_LOW, PH_TRIG_HIGH: begin
        r.trig = (st.ph == PH_TRIG_HIGH);
        st.timer = step_sat(st.timer);
        if (st.timer >= tlen) begin
          st.timer = '0;
          if (st.ph == PH_TRIG_LOW) begin
            st.ph = PH_TRIG_HIGH;
          end else begin
            st.ph = PH_WAIT_RISE;
            st.since = '0;
          end
        end
      end
      PH_WAIT_RISE: begin
        st.since = step_sat(st.since);
        if (t.echo) begin
          st.ph = PH_TIME_HIGH;
          st.timer = '0;
        end else if (st.since > echo_limit) begin
          r.done = 1'b1;
          r.tmo = 1'b1;
        end
      end
      PH_TIME_HIGH: begin
        st.since = step_sat(st.since);
        st.timer = step_sat(st.timer);
        if (!t.echo) begin
          s = {1'b0, st.sum} + (SUM_BITS + 1)'(st.timer);
          st.sum = s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
          if (st.since >= min_gap) sample_end = 1'b1;
          else st.ph = PH_HOLD;
        end else if (st.timer > echo_limit) begin
          r.done = 1'b1;
          r.tmo = 1'b1;
        end
      end
      PH_HOLD: begin
        st.since = step_sat(st.since);
        if (st.since >= min_gap) sample_end = 1'b1;
      end
      default: ;
    endcase
    if (sample_end) begin
      st.taken = st.taken + 1'b1;
      st.timer = '0;
      if (st.taken >= st.wanted) r.done = 1'b1;
      else st.ph = PH_TRIG_LOW;
    end
    if (r.done) begin
      // Timed-out runs still divide by the full requested count.
      q = (st.wanted == '0) ? '0 : st.sum / st.wanted;
      r.avg = (q > AVG_MAX) ? AVG_MAX : q[AVG_BITS-1:0];
      st.ph = PH_IDLE;
      st.timer = '0;
    end
    r.busy = (st.ph != PH_IDLE);
    return r;
  endfunction

  function automatic bit roll(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: hold the beat until taken, predict on every accepted tick.
  always @(posedge clk) begin : drive_ticks
    tick_t seen;
    tick_t nxt;
    int    gap_pct;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        seen.start = in_ch.cmd;
        seen.echo = in_ch.echo_level;
        seen.count = in_ch.sample_count;
        pending_readings.push_back(ranger_tick(model_st, seen));
      end
      gap_pct = (pace == IDLE_SEND) ? 79 : (pace == IDLE_BOTH) ? 30 : 0;
      if (tick_queue.size() != 0 && !roll(gap_pct)) begin
        nxt = tick_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.cmd <= nxt.start;
        in_ch.echo_level <= nxt.echo;
        in_ch.sample_count <= nxt.count;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string field, input logic [AVG_BITS-1:0] want,
                             input logic [AVG_BITS-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
    end
  endtask

  // Monitor: take readings under random back-pressure and compare with the oldest one due.
  always @(posedge clk) begin : watch_readings
    reading_t got;
    reading_t want;
    int       stall_pct;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.trig = out_ch.trigger_level;
        got.busy = out_ch.busy_res;
        got.done = out_ch.done_res;
        got.tmo = out_ch.timed_out;
        got.avg = out_ch.average_us;
        if (pending_readings.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected reading, expected none actual %p", $time, got);
        end else begin
          want = pending_readings.pop_front();
          check_field("trigger_level", AVG_BITS'(want.trig), AVG_BITS'(got.trig));
          check_field("busy_res", AVG_BITS'(want.busy), AVG_BITS'(got.busy));
          check_field("done_res", AVG_BITS'(want.done), AVG_BITS'(got.done));
          check_field("timed_out", AVG_BITS'(want.tmo), AVG_BITS'(got.tmo));
          check_field("average_us", want.avg, got.avg);
        end
      end
      stall_pct = (pace == IDLE_RECV) ? 79 : (pace == IDLE_BOTH) ? 30 : 0;
      out_ch.ready <= !roll(stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("ultrasonic_echo_ranger_unit_test: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic emit(input logic start, input logic echo, input logic [CNT_BITS-1:0] count);
    tick_t t;
    t.start = start;
    t.echo = echo;
    t.count = count;
    void'(ranger_tick(gen_st, t));
    tick_queue.push_back(t);
    made++;
  endtask

  // One measurement run against an emulated target: the echo rises rise_delay ticks after
  // the trigger and stays high for high_len ticks. Negative fixes mean pick at random.
  task automatic measure_run(input int count, input int fail_pct, input int fix_rise,
                             input int fix_high);
    int   rise_delay;
    int   high_len;
    int   low_seen;
    int   hi_seen;
    int   lim;
    logic echo;
    rise_delay = 0;
    high_len = 1;
    low_seen = 0;
    hi_seen = 0;
    emit(1'b1, 1'($urandom), CNT_BITS'(count));
    while (gen_st.ph != PH_IDLE) begin
      lim = int'(echo_limit);
      case (gen_st.ph)
        PH_WAIT_RISE: begin
          echo = (low_seen >= rise_delay);
          low_seen++;
        end
        PH_TIME_HIGH: begin
          hi_seen++;
          echo = (hi_seen < high_len);
        end
        PH_HOLD: echo = 1'($urandom);
        default: begin
          // Trigger phases: echo is ignored; choose the next sample's target.
          echo = 1'($urandom);
          low_seen = 0;
          hi_seen = 0;
          rise_delay = (fix_rise >= 0) ? fix_rise : $urandom_range(0, (lim < 24) ? lim : 24);
          high_len = (fix_high > 0) ? fix_high :
                     $urandom_range(1, (lim + 1 < 24) ? lim + 1 : 24);
          if (fix_rise < 0 && lim <= 200 && roll(fail_pct)) begin
            if ($urandom_range(0, 1)) rise_delay = lim + 1;
            else high_len = lim + 2;
          end
        end
      endcase
      // Stray starts land while busy and must be dropped.
      emit($urandom_range(0, 7) == 0, echo, CNT_BITS'($urandom));
    end
  endtask

  // Random garbage, then drain with a silent echo until the block is idle again.
  task automatic noise_burst();
    repeat ($urandom_range(3, 30)) emit($urandom_range(0, 3) == 0, 1'($urandom),
                                        CNT_BITS'($urandom));
    while (gen_st.ph != PH_IDLE) emit(1'b0, 1'b0, CNT_BITS'($urandom));
  endtask

  task automatic fill_phase(input int budget, input bit noise);
    int pick;
    made = 0;
    while (made < budget) begin
      repeat ($urandom_range(0, 4)) emit(1'b0, 1'($urandom), CNT_BITS'($urandom));
      pick = $urandom_range(0, 99);
      if (noise && pick < 15) noise_burst();
      else if (pick < 23) measure_run(0, 0, -1, -1);
      else if (pick < 33) measure_run($urandom_range(5, 255), 35, -1, -1);
      else measure_run($urandom_range(1, 4), 8, -1, -1);
    end
  endtask

  task automatic settle();
    @(posedge clk);
    while (tick_queue.size() != 0 || in_ch.valid || pending_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_TRIGGER_US:   trig_len = value[TRIG_BITS-1:0];
      CFG_ECHO_TIMEOUT: echo_limit = value;
      CFG_MIN_CYCLE:    min_gap = value;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input logic [TRIG_BITS-1:0] t, input logic [TIMER_BITS-1:0] lim,
                          input logic [TIMER_BITS-1:0] gap);
    write_reg(CFG_TRIGGER_US, CFG_BITS'(t));
    write_reg(CFG_ECHO_TIMEOUT, lim);
    write_reg(CFG_MIN_CYCLE, gap);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.echo_level = 1'b0;
    in_ch.sample_count = '0;
    out_ch.ready = 1'b0;
    model_st = idle_state();
    gen_st = idle_state();
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one sample on the reset settings, then the corner cases.
    measure_run(1, 0, 3, 5);
    settle();
    set_regs(8'd1, 16'd2, 16'd0);
    emit(1'b0, 1'b1, 8'd0);
    emit(1'b0, 1'b0, 8'd255);
    measure_run(0, 0, -1, -1);
    measure_run(1, 0, 0, 1);
    measure_run(2, 0, 2, 3);
    measure_run(3, 0, 3, -1);
    measure_run(1, 0, 0, 4);
    settle();

    // Zero trigger length, an echo timeout of 1, full sample count.
    set_regs(8'd0, 16'd1, 16'd0);
    measure_run(255, 0, 0, 1);
    fill_phase(100, 1'b1);
    settle();

    pace = IDLE_SEND;
    set_regs(8'd3, 16'd40, 16'd20);
    fill_phase(100, 1'b1);
    settle();

    pace = IDLE_RECV;
    set_regs(8'd2, 16'd30, 16'd5);
    fill_phase(100, 1'b1);
    settle();

    // Longest echo timeout: a long pulse is timed with no timeout, then held.
    pace = IDLE_BOTH;
    set_regs(8'd20, 16'hFFFF, 16'd40);
    measure_run(1, 0, 0, 30);
    settle();

    set_regs(TRIG_BITS'($urandom_range(1, 4)), TIMER_BITS'($urandom_range(8, 60)),
             TIMER_BITS'($urandom_range(0, 30)));
    fill_phase(150, 1'b1);
    settle();

    if (mismatches == 0) begin
      $display("ultrasonic_echo_ranger_unit_test: PASS");
    end else begin
      $display("ultrasonic_echo_ranger_unit_test: FAIL");
    end
    $finish;
  end

endmodule
